[design/point_frame_parser_core_macros.svh]
// ----------------------------------------------------------------------------
// point_frame_parser_core_macros
// assertion macros for the checker of the point frame parser
// ----------------------------------------------------------------------------
`ifndef POINT_FRAME_PARSER_CORE_MACROS_SVH
`define POINT_FRAME_PARSER_CORE_MACROS_SVH

// plain property, clocked on clk_i, off while reset is asserted
`define PFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication built on the macro above
`define PFP_ASSERT_IMPL(lbl, ante, cons, msg) \
  `PFP_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[design/pfp_pkg.sv]
// ----------------------------------------------------------------------------
// pfp_pkg
// constants shared by the point frame parser core and its checker
// ----------------------------------------------------------------------------
`default_nettype none

package pfp_pkg;

  parameter int unsigned BufferDepth = 64;

  parameter logic [7:0] HdrByte = 8'hFF;
  parameter logic [7:0] TypeSet = 8'h02;
  parameter logic [7:0] TypePos = 8'h03;
  parameter logic [7:0] TrlByte = 8'hFE;

  parameter int unsigned LenW     = 6;
  parameter int unsigned InDataW  = 16;
  parameter int unsigned OutDataW = 40;

  // point_kind codes
  parameter logic KindSet = 1'b0;
  parameter logic KindPos = 1'b1;

endpackage

`default_nettype wire

[design/point_frame_parser_core.sv]
// an accepted input word passes the input register, then the result register, to the master side
// throughput: one byte per cycle; the input register and the result register each
// advance whenever the result register is empty or being taken
// a result word appears only for the byte that closes a frame
// reset: asynchronous, active low; clears the parser state, head bytes and both valids
// ----------------------------------------------------------------------------
// point_frame_parser_core
// byte-serial deframer for coordinate frames, header 0xff, type, body, 0xfe 0xfe
// ----------------------------------------------------------------------------
`default_nettype none

module point_frame_parser_core #(
  parameter int unsigned BUFFER_DEPTH = pfp_pkg::BufferDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] rx_byte, [8] setpoint_locked, [15:9] zero
  input  wire logic [pfp_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // [15:0] x_coord, [31:16] y_coord, [32] point_taken, [38:33] body_length, [39] zero
  output logic [pfp_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // [0] point_kind
  output logic                              m_axis_tuser_o
);

  localparam int unsigned CntW = $clog2(BUFFER_DEPTH);
  localparam logic [CntW-1:0] CntMax = CntW'(BUFFER_DEPTH - 1);
  localparam logic [CntW-1:0] HeadCnt = CntW'(4);

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhType   = 2'd1,
    PhBody   = 2'd2
  } phase_e;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_locked_q;

  // parser state
  phase_e          phase_q, phase_d;
  logic            kind_q, kind_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      head_q [4];
  logic [7:0]      head_d [4];
  logic [7:0]      prev_q;

  // result register
  logic                        out_valid_q;
  logic [pfp_pkg::OutDataW-1:0] out_data_q;
  logic                        out_kind_q;

  logic advance;
  logic frame_end;
  logic taken;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    count_d   = count_q;
    head_d    = head_q;
    frame_end = 1'b0;
    case (phase_q)
      PhHeader: begin
        if (in_byte_q == pfp_pkg::HdrByte) begin
          phase_d = PhType;
          count_d = '0;
        end
      end
      PhType: begin
        if (in_byte_q == pfp_pkg::TypeSet) begin
          phase_d = PhBody;
          kind_d  = pfp_pkg::KindSet;
        end else if (in_byte_q == pfp_pkg::TypePos) begin
          phase_d = PhBody;
          kind_d  = pfp_pkg::KindPos;
        end
      end
      PhBody: begin
        if (in_byte_q == pfp_pkg::TrlByte && prev_q == pfp_pkg::TrlByte) begin
          phase_d   = PhHeader;
          frame_end = 1'b1;
          // short frame: the terminating zero lands in a head byte
          if (count_q < HeadCnt) begin
            head_d[count_q[1:0]] = 8'h00;
          end
        end else if (count_q < CntMax) begin
          if (count_q < HeadCnt) begin
            head_d[count_q[1:0]] = in_byte_q;
          end
          count_d = count_q + CntW'(1);
        end
      end
      default: ;
    endcase
  end

  assign taken = (kind_q == pfp_pkg::KindPos) || !in_locked_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PhHeader;
      kind_q      <= pfp_pkg::KindSet;
      count_q     <= '0;
      head_q      <= '{default: 8'h00};
      prev_q      <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && frame_end;
      end
      if (advance && in_valid_q) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        count_q <= count_d;
        head_q  <= head_d;
        prev_q  <= in_byte_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q   <= s_axis_tdata_i[7:0];
      in_locked_q <= s_axis_tdata_i[8];
    end
    if (advance && in_valid_q && frame_end) begin
      out_kind_q <= kind_q;
      out_data_q <= {1'b0, pfp_pkg::LenW'(count_q), taken,
                     head_d[2], head_d[3], head_d[0], head_d[1]};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;

endmodule

`default_nettype wire

[design/pfp_checker.sv]
// ----------------------------------------------------------------------------
// pfp_checker
// port-level checks for the point frame parser core, bound into the core module
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_frame_parser_core_macros.svh"

module pfp_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid_i,
  input wire logic                         s_axis_tready_o,
  input wire logic [pfp_pkg::InDataW-1:0]  s_axis_tdata_i,
  input wire logic                         m_axis_tvalid_o,
  input wire logic                         m_axis_tready_i,
  input wire logic [pfp_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic                         m_axis_tuser_o
);

  logic                       in_stall;
  logic                       out_stall;
  logic                       refused;
  logic                       pos_kind;
  logic [pfp_pkg::OutDataW:0] out_word;

  assign in_stall  = s_axis_tvalid_i && !s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign refused   = m_axis_tvalid_o && !m_axis_tdata_o[32];
  assign pos_kind  = (m_axis_tuser_o == pfp_pkg::KindPos);
  assign out_word  = {m_axis_tuser_o, m_axis_tdata_o};

  // a stalled result word holds still
  `PFP_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid_o && $stable(out_word), "stalled word moved")

  // a waiting input word holds still
  `PFP_ASSERT(a_in_hold, in_stall |=> s_axis_tvalid_i && $stable(s_axis_tdata_i), "input word moved")

  // the input side never backs up while the output side drains
  `PFP_ASSERT_IMPL(a_ready_flow, m_axis_tready_i, s_axis_tready_o, "input stalled with output ready")

  // only a locked set point is refused
  `PFP_ASSERT_IMPL(a_refused_kind, refused, !pos_kind, "position frame refused")

  // nothing comes out right after reset
  `PFP_ASSERT_IMPL(a_reset_quiet, !$past(rst_ni), !m_axis_tvalid_o, "result word right after reset")

endmodule

bind point_frame_parser_core pfp_checker u_pfp_checker (.*);

`default_nettype wire
